/* rtl/dpdc_pkg.sv */
// ----------------------------------------------------------------------------
// Debug packet deframer package
// Shared types, codes and character helpers for the deframer and classifier.
// ----------------------------------------------------------------------------
package dpdc_pkg;

  localparam int unsigned MaxPacketDefault = 1024;

  typedef enum logic [3:0] {
    PhIdle    = 4'b0001,
    PhPayload = 4'b0010,
    PhDigit1  = 4'b0100,
    PhDigit2  = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    EvNone       = 3'd0,
    EvPacketOk   = 3'd1,
    EvSumMismatch = 3'd2,
    EvMalformed  = 3'd3,
    EvRetransmit = 3'd4,
    EvAck        = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    RkEmpty    = 3'd0,
    RkHwbreak  = 3'd1,
    RkOne      = 3'd2,
    RkRegDump  = 3'd3,
    RkStop     = 3'd4,
    RkAckOnly  = 3'd5
  } reply_kind_e;

  localparam logic [7:0] ChAck      = 8'h2B;
  localparam logic [7:0] ChNak      = 8'h2D;
  localparam logic [7:0] ChStart    = 8'h24;
  localparam logic [7:0] ChHash     = 8'h23;
  localparam logic [7:0] ChQuery    = 8'h71;
  localparam logic [7:0] ChSetThread = 8'h48;
  localparam logic [7:0] ChRegRead  = 8'h67;
  localparam logic [7:0] ChStopQuery = 8'h3F;

  localparam logic [71:0] SupportedStr = "Supported";
  localparam logic [63:0] AttachedStr  = "Attached";
  localparam logic [15:0] ThreadGStr   = "g0";
  localparam logic [23:0] ThreadCStr   = "c-1";

  localparam int unsigned SupportedLen = 9;
  localparam int unsigned AttachedLen  = 8;
  localparam int unsigned ThreadGLen   = 2;
  localparam int unsigned ThreadCLen   = 3;

  typedef enum int unsigned {
    HitSupported = 0,
    HitAttached  = 1,
    HitThreadG   = 2,
    HitThreadC   = 3
  } hit_bit_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] b);
    hex_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.value = 4'(b - 8'h37);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

/* rtl/dpdc_if.sv */
// ----------------------------------------------------------------------------
// Debug packet deframer channels
// Valid/ready channels for received bytes and for per-byte results.
// ----------------------------------------------------------------------------
interface dpdc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dpdc_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [2:0] reply_kind;
  logic [7:0] computed_sum;

  modport source (output valid, output event_res, output reply_kind,
                  output computed_sum, input ready);
  modport sink   (input valid, input event_res, input reply_kind,
                  input computed_sum, output ready);
endinterface

/* rtl/dpdc_prefix_match.sv */
// ----------------------------------------------------------------------------
// Debug packet prefix matcher
// Clears the match flag of each known payload prefix that the byte breaks.
// ----------------------------------------------------------------------------
module dpdc_prefix_match
  import dpdc_pkg::*;
#(
  parameter int unsigned CountWidth = 11
) (
  input  logic [CountWidth-1:0] count_i,
  input  logic [7:0]            byte_i,
  input  logic [3:0]            hits_i,
  output logic [3:0]            hits_o
);

  logic       pos_ok;
  logic [3:0] pos;

  always_comb begin
    pos_ok = (count_i >= CountWidth'(1)) && (count_i <= CountWidth'(SupportedLen));
    pos    = count_i[3:0] - 4'd1;
    hits_o = hits_i;
    if (pos_ok) begin
      if (32'(pos) < SupportedLen &&
          SupportedStr[8*(SupportedLen-1-32'(pos)) +: 8] != byte_i) begin
        hits_o[HitSupported] = 1'b0;
      end
      if (32'(pos) < AttachedLen &&
          AttachedStr[8*(AttachedLen-1-32'(pos)) +: 8] != byte_i) begin
        hits_o[HitAttached] = 1'b0;
      end
      if (32'(pos) < ThreadGLen &&
          ThreadGStr[8*(ThreadGLen-1-32'(pos)) +: 8] != byte_i) begin
        hits_o[HitThreadG] = 1'b0;
      end
      if (32'(pos) < ThreadCLen &&
          ThreadCStr[8*(ThreadCLen-1-32'(pos)) +: 8] != byte_i) begin
        hits_o[HitThreadC] = 1'b0;
      end
    end
  end

endmodule

/* rtl/debug_packet_deframer_classifier.sv */
// ----------------------------------------------------------------------------
// Debug packet deframer and classifier
// Frames debug link packets, checks their checksum and classifies replies.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one received link byte per item. res_o carries exactly one
//   result item per byte: an event code, a reply class that is meaningful
//   with a good packet, and the running payload sum.
//   Outside a packet '+' reports an ack and '-' a retransmit request; '$'
//   opens a packet whose payload is summed until '#', after which two hex
//   digits are checked against the sum. The second digit gives the outcome.
//   A result item is offered after its byte is accepted: the byte is held
//   in an input register, and the state update and result are formed in
//   one pass into the result register. Throughput is one byte per cycle
//   while the receiver does not stall the result register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; in_i.ready then drops until the
//   result is taken.
//   Reset puts the block outside any packet with a zero sum and no items
//   in flight.
// ----------------------------------------------------------------------------
module debug_packet_deframer_classifier
  import dpdc_pkg::*;
#(
  parameter int unsigned MaxPacket = MaxPacketDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dpdc_byte_if.sink  in_i,
  dpdc_res_if.source res_o
);

  localparam int unsigned CountWidth = $clog2(MaxPacket + 1);

  logic                  byte_valid_q;
  logic [7:0]            byte_q;
  logic                  advance;
  logic                  process;

  phase_e                phase_q, phase_d;
  logic [7:0]            sum_q, sum_d;
  logic [CountWidth-1:0] count_q, count_d;
  logic [3:0]            nibble_q, nibble_d;
  logic [7:0]            lead_q, lead_d;
  logic [3:0]            hits_q, hits_d, hits_match;
  logic                  bad_q, bad_d;

  logic                  out_valid_q;
  event_e                ev_q, ev_d;
  reply_kind_e           kind_q, kind_d;
  logic [7:0]            out_sum_q;

  hex_t                  hex;
  logic [CountWidth-1:0] count_inc;

  assign advance    = !out_valid_q || res_o.ready;
  assign process    = byte_valid_q && advance;
  assign in_i.ready = !byte_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      byte_valid_q <= 1'b1;
    end else if (advance) begin
      byte_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.rx_byte;
    end
  end

  dpdc_prefix_match #(
    .CountWidth(CountWidth)
  ) u_prefix_match (
    .count_i(count_q),
    .byte_i (byte_q),
    .hits_i (hits_q),
    .hits_o (hits_match)
  );

  function automatic reply_kind_e classify(logic [CountWidth-1:0] count,
                                           logic [7:0] lead, logic [3:0] hits);
    reply_kind_e k;
    k = RkEmpty;
    if (count != '0) begin
      case (lead)
        ChQuery: begin
          if (hits[HitSupported] && count >= CountWidth'(SupportedLen + 1)) begin
            k = RkHwbreak;
          end else if (hits[HitAttached] &&
                       count >= CountWidth'(AttachedLen + 1)) begin
            k = RkOne;
          end
        end
        ChSetThread: begin
          if (!((hits[HitThreadG] && count >= CountWidth'(ThreadGLen + 1)) ||
                (hits[HitThreadC] && count >= CountWidth'(ThreadCLen + 1)))) begin
            k = RkAckOnly;
          end
        end
        ChRegRead:   k = RkRegDump;
        ChStopQuery: k = RkStop;
        default:     k = RkEmpty;
      endcase
    end
    return k;
  endfunction

  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    count_d   = count_q;
    nibble_d  = nibble_q;
    lead_d    = lead_q;
    hits_d    = hits_q;
    bad_d     = bad_q;
    ev_d      = EvNone;
    kind_d    = RkEmpty;
    hex       = hex_decode(byte_q);
    count_inc = count_q;
    unique case (phase_q)
      PhIdle: begin
        if (byte_q == ChAck) begin
          ev_d = EvAck;
        end else if (byte_q == ChNak) begin
          ev_d = EvRetransmit;
        end else if (byte_q == ChStart) begin
          phase_d  = PhPayload;
          sum_d    = 8'd0;
          count_d  = '0;
          nibble_d = 4'd0;
          lead_d   = 8'd0;
          hits_d   = 4'hF;
          bad_d    = 1'b0;
        end
      end
      PhPayload: begin
        if (byte_q == ChHash) begin
          phase_d = PhDigit1;
        end else begin
          sum_d = sum_q + byte_q;
          if (byte_q == 8'd0) begin
            bad_d = 1'b1;
          end
          if (count_q == '0) begin
            lead_d = byte_q;
          end else begin
            hits_d = hits_match;
          end
          if (count_q < CountWidth'(MaxPacket)) begin
            count_inc = count_q + CountWidth'(1);
          end
          count_d = count_inc;
          if (count_inc > CountWidth'(MaxPacket - 5)) begin
            bad_d = 1'b1;
          end
        end
      end
      PhDigit1: begin
        phase_d  = PhDigit2;
        nibble_d = hex.value;
        if (!hex.valid) begin
          bad_d = 1'b1;
        end
      end
      PhDigit2: begin
        phase_d = PhIdle;
        if (!hex.valid || bad_q) begin
          ev_d = EvMalformed;
        end else if ({nibble_q, hex.value} != sum_q) begin
          ev_d = EvSumMismatch;
        end else begin
          ev_d   = EvPacketOk;
          kind_d = classify(count_q, lead_q, hits_q);
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      sum_q    <= 8'd0;
      count_q  <= '0;
      nibble_q <= 4'd0;
      lead_q   <= 8'd0;
      hits_q   <= 4'hF;
      bad_q    <= 1'b0;
    end else if (process) begin
      phase_q  <= phase_d;
      sum_q    <= sum_d;
      count_q  <= count_d;
      nibble_q <= nibble_d;
      lead_q   <= lead_d;
      hits_q   <= hits_d;
      bad_q    <= bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= byte_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      ev_q      <= ev_d;
      kind_q    <= kind_d;
      out_sum_q <= sum_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.event_res    = ev_q;
  assign res_o.reply_kind   = kind_q;
  assign res_o.computed_sum = out_sum_q;

endmodule

/* rtl/dpdc_checker.sv */
// ----------------------------------------------------------------------------
// Debug packet deframer checker
// Port-level properties of the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dpdc_checker
  import dpdc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [2:0] event_res_i,
  input logic [2:0] reply_kind_i
);

  // A byte can be refused only while a result waits on a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (res_valid_i && !res_ready_i))
    else $error("input refused without a stalled result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i)
    else $error("result item dropped while stalled");

  // A reply class is reported only with a good packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (reply_kind_i == RkEmpty || event_res_i == EvPacketOk))
    else $error("reply class given without a good packet");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (event_res_i <= EvAck))
    else $error("undefined event code");

  // A result item only appears after a byte has been accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without an accepted byte");

endmodule

bind debug_packet_deframer_classifier dpdc_checker u_dpdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .event_res_i (res_o.event_res),
  .reply_kind_i(res_o.reply_kind)
);

/* sim/tb_dpdc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debug packet deframer checker
// Watches the byte and result channels, predicts one result item per
// accepted byte from its own model of the framing state, and compares each
// result item field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_dpdc_checker
  import dpdc_pkg::*;
#(
  parameter int unsigned MaxPacket = MaxPacketDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dpdc_byte_if        byte_mon,
  dpdc_res_if         res_mon,
  output int unsigned faults_o,
  output int unsigned pending_o
);

  typedef struct packed {
    event_e      ev;
    reply_kind_e kind;
    logic [7:0]  sum;
  } byte_result_t;

  byte_result_t awaited_q[$];
  int unsigned  fault_count;

  phase_e      phase;
  logic [7:0]  run_sum;
  int unsigned pay_len;
  logic [3:0]  high_nib;
  logic [7:0]  lead;
  logic [3:0]  hits;
  logic        bad;

  function automatic int hex_val(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void drop_hit(int unsigned pos, logic [7:0] b, logic [71:0] str,
                                   int unsigned len, hit_bit_e hit);
    if (pos < len && str[8 * (len - 1 - pos) +: 8] != b) hits[hit] = 1'b0;
  endfunction

  function automatic reply_kind_e reply_class();
    if (pay_len == 0) return RkEmpty;
    case (lead)
      ChQuery: begin
        if (hits[HitSupported] && pay_len >= SupportedLen + 1) return RkHwbreak;
        if (hits[HitAttached] && pay_len >= AttachedLen + 1) return RkOne;
        return RkEmpty;
      end
      ChSetThread: begin
        if ((hits[HitThreadG] && pay_len >= ThreadGLen + 1) ||
            (hits[HitThreadC] && pay_len >= ThreadCLen + 1)) return RkEmpty;
        return RkAckOnly;
      end
      ChRegRead:   return RkRegDump;
      ChStopQuery: return RkStop;
      default:     return RkEmpty;
    endcase
  endfunction

  function automatic byte_result_t absorb_byte(logic [7:0] b);
    byte_result_t r;
    int hv;
    r.ev   = EvNone;
    r.kind = RkEmpty;
    case (phase)
      PhIdle: begin
        if (b == ChAck) begin
          r.ev = EvAck;
        end else if (b == ChNak) begin
          r.ev = EvRetransmit;
        end else if (b == ChStart) begin
          phase    = PhPayload;
          run_sum  = 8'h00;
          pay_len  = 0;
          high_nib = 4'h0;
          lead     = 8'h00;
          hits     = 4'hF;
          bad      = 1'b0;
        end
      end
      PhPayload: begin
        if (b == ChHash) begin
          phase = PhDigit1;
        end else begin
          run_sum = run_sum + b;
          if (b == 8'h00) bad = 1'b1;
          if (pay_len == 0) begin
            lead = b;
          end else begin
            drop_hit(pay_len - 1, b, SupportedStr, SupportedLen, HitSupported);
            drop_hit(pay_len - 1, b, 72'(AttachedStr), AttachedLen, HitAttached);
            drop_hit(pay_len - 1, b, 72'(ThreadGStr), ThreadGLen, HitThreadG);
            drop_hit(pay_len - 1, b, 72'(ThreadCStr), ThreadCLen, HitThreadC);
          end
          if (pay_len < MaxPacket) pay_len++;
          if (pay_len > MaxPacket - 5) bad = 1'b1;
        end
      end
      PhDigit1: begin
        hv = hex_val(b);
        if (hv < 0) begin
          bad      = 1'b1;
          high_nib = 4'h0;
        end else begin
          high_nib = hv[3:0];
        end
        phase = PhDigit2;
      end
      default: begin
        hv    = hex_val(b);
        phase = PhIdle;
        if (hv < 0 || bad) begin
          r.ev = EvMalformed;
        end else if ({high_nib, hv[3:0]} != run_sum) begin
          r.ev = EvSumMismatch;
        end else begin
          r.ev   = EvPacketOk;
          r.kind = reply_class();
        end
      end
    endcase
    r.sum = run_sum;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    byte_result_t want;
    if (!rst_ni) begin
      phase       = PhIdle;
      run_sum     = 8'h00;
      pay_len     = 0;
      high_nib    = 4'h0;
      lead        = 8'h00;
      hits        = 4'hF;
      bad         = 1'b0;
      fault_count = 0;
      awaited_q.delete();
      faults_o  <= 0;
      pending_o <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (awaited_q.size() == 0) begin
          if (fault_count < 10) begin
            $display("%0t: result item with none expected: event %0d kind %0d sum %02h",
                     $realtime, res_mon.event_res, res_mon.reply_kind, res_mon.computed_sum);
          end
          fault_count++;
        end else begin
          want = awaited_q.pop_front();
          if (res_mon.event_res !== want.ev || res_mon.reply_kind !== want.kind ||
              res_mon.computed_sum !== want.sum) begin
            if (fault_count < 10) begin
              $display({"%0t: expected event %0d kind %0d sum %02h, ",
                        "got event %0d kind %0d sum %02h"},
                       $realtime, want.ev, want.kind, want.sum, res_mon.event_res,
                       res_mon.reply_kind, res_mon.computed_sum);
            end
            fault_count++;
          end
        end
      end
      if (byte_mon.valid && byte_mon.ready) awaited_q.push_back(absorb_byte(byte_mon.rx_byte));
      pending_o <= unsigned'(awaited_q.size());
      faults_o  <= fault_count;
    end
  end

endmodule

/* sim/tb_debug_packet_deframer_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debug packet deframer and classifier testbench
// Sends link bytes: directed packets for every reply class and error case,
// then random well-formed, broken and noise traffic, with random gaps and
// result stalls. A separate checker predicts and compares the result items.
// ----------------------------------------------------------------------------
module tb_debug_packet_deframer_classifier;
  import dpdc_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandomItems = 750;

  typedef logic [7:0] bytes_t[$];

  typedef enum int unsigned {
    FrGood,
    FrBadSum,
    FrBadHigh,
    FrBadLow
  } frame_end_e;

  logic        clk_i;
  logic        rst_ni;
  bit          calm;
  int unsigned sent_count;
  int unsigned idle_cycles;
  int unsigned faults;
  int unsigned pending;

  dpdc_byte_if byte_ch ();
  dpdc_res_if  res_ch ();

  debug_packet_deframer_classifier #(
    .MaxPacket(MaxPacketDefault)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_ch),
    .res_o (res_ch)
  );

  tb_dpdc_checker #(
    .MaxPacket(MaxPacketDefault)
  ) checker_i (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_mon (byte_ch),
    .res_mon  (res_ch),
    .faults_o (faults),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic bytes_t text(input string s);
    bytes_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    if ($urandom_range(0, 19) == 0) return 8'h00;
    do b = 8'($urandom_range(1, 255)); while (b == ChHash);
    return b;
  endfunction

  function automatic bytes_t filler(input int unsigned n);
    bytes_t q;
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(1, 255)); while (b == ChHash);
      q.push_back(b);
    end
    return q;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return 8'("0") + nib;
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + nib - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_hex(b));
    return b;
  endfunction

  function automatic bytes_t random_payload();
    bytes_t q;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: q = text("qSupported");
      1: q = text("qAttached");
      2: q = text("Hg0");
      3: q = text("Hc-1");
      4: q = text("H");
      5: q = text("g");
      6: q = text("?");
      default: ;
    endcase
    if (pick < 4 && $urandom_range(0, 2) == 0) q = q[0:$urandom_range(0, q.size() - 1)];
    if (q.size() > 0 && $urandom_range(0, 3) == 0) begin
      q[$urandom_range(0, q.size() - 1)] = payload_byte();
    end
    repeat ($urandom_range(0, pick > 6 ? 12 : 3)) q.push_back(payload_byte());
    return q;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    sent_count++;
  endtask

  task automatic put_frame(input bytes_t payload, input frame_end_e ending);
    logic [7:0] sum;
    logic [7:0] cks;
    sum = 8'h00;
    foreach (payload[i]) sum += payload[i];
    cks = (ending == FrBadSum) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    put_byte(ChStart);
    foreach (payload[i]) put_byte(payload[i]);
    put_byte(ChHash);
    put_byte(ending == FrBadHigh ? non_hex() : hex_char(cks[7:4]));
    put_byte(ending == FrBadLow ? non_hex() : hex_char(cks[3:0]));
  endtask

  task automatic hold_until_drained();
    byte_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : drain_results
    int stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
    end
  end

  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    bytes_t nul_q;
    int unsigned goal;
    int unsigned choice;
    int unsigned r;
    calm            = 1'b0;
    sent_count      = 0;
    rst_ni          <= 1'b0;
    byte_ch.valid   <= 1'b0;
    byte_ch.rx_byte <= 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put_byte(ChAck);
    put_byte(ChNak);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(ChHash);
    put_frame(text(""), FrGood);
    put_frame(text("qSupported"), FrGood);
    put_frame(text("qSupportedX"), FrGood);
    put_frame(text("qSupporte"), FrGood);
    put_frame(text("qAttached"), FrGood);
    put_frame(text("qOther"), FrGood);
    put_frame(text("g"), FrGood);
    put_frame(text("?"), FrGood);
    put_frame(text("Hg0"), FrGood);
    put_frame(text("Hc-1"), FrGood);
    put_frame(text("Hc0"), FrGood);
    put_frame(text("H"), FrGood);
    put_frame(text("m$+-"), FrGood);
    put_frame({8'hFF}, FrGood);
    put_frame(text("g"), FrBadSum);
    put_frame(text("?"), FrBadHigh);
    put_frame(text("qAttached"), FrBadLow);
    nul_q = text("g");
    nul_q.push_back(8'h00);
    put_frame(nul_q, FrGood);
    calm = 1'b1;
    put_frame(filler(MaxPacketDefault - 5), FrGood);
    put_frame(filler(MaxPacketDefault - 4), FrGood);
    put_frame(filler(MaxPacketDefault + 6), FrGood);
    calm = 1'b0;
    hold_until_drained();

    goal = sent_count + RandomItems;
    while (sent_count < goal) begin
      calm   = ($urandom_range(0, 4) == 0);
      choice = $urandom_range(0, 99);
      if (choice < 8) begin
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
      end else if (choice < 12) begin
        put_byte(ChStart);
        repeat ($urandom_range(0, 5)) put_byte(payload_byte());
      end else if (choice < 20) begin
        put_byte($urandom_range(0, 1) ? ChAck : ChNak);
      end else begin
        r = $urandom_range(0, 99);
        put_frame(random_payload(), r < 78 ? FrGood : r < 88 ? FrBadSum :
                                    r < 94 ? FrBadHigh : FrBadLow);
      end
      if ($urandom_range(0, 59) == 0) hold_until_drained();
    end

    calm = 1'b0;
    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (faults == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
